@@ rtl/diffie_hellman_modexp_unit_defines.svh @@
// assertion macros for the diffie-hellman modular exponentiation unit
`ifndef DIFFIE_HELLMAN_MODEXP_UNIT_DEFINES_SVH
`define DIFFIE_HELLMAN_MODEXP_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define DHM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define DHM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dhm_pkg.sv @@
// shared constants for the diffie-hellman modular exponentiation unit
package dhm_pkg;

    localparam int NUM_WIDTH_DEF = 31;

    // configuration reset values
    localparam int MOD_RESET = 23;
    localparam int GEN_RESET = 5;

    // configuration register indexes
    localparam logic CFG_MODULUS   = 1'b0;
    localparam logic CFG_GENERATOR = 1'b1;

    // item operations
    localparam logic OP_PUBLIC = 1'b0;
    localparam logic OP_SHARED = 1'b1;

    typedef logic [2:0] t_state;

endpackage

@@ rtl/diffie_hellman_modexp_unit.sv @@
// diffie-hellman modular exponentiation unit with one shared modular adder
//
//  channel   direction  handshake                  payload
//  command   in         i_start, o_busy            i_op, i_value
//  result    out        o_done (one-cycle strobe)  o_result
//  config    in         i_cfg_valid, o_cfg_ready   i_cfg_index, i_cfg_data
//
// one item reduces the base modulo m one bit at a time, then per exponent bit does one
// check and up to two shift-and-add multiplies (acc times base, then base squared).
// all arithmetic goes through the single modular adder: one add or doubling a cycle.
// busy stays high from the accepting edge until the done strobe cycle ends.
// synchronous active-low reset: modulus 23, generator 5, stored exponent 0.
// results cannot be stalled; o_result holds its value until the next item.
`include "diffie_hellman_modexp_unit_defines.svh"

module diffie_hellman_modexp_unit
    import dhm_pkg::*;
#(
    parameter int NUM_WIDTH = NUM_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_op,
    input  logic [NUM_WIDTH-1:0] i_value,
    output logic                 o_done,
    output logic [NUM_WIDTH-1:0] o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [NUM_WIDTH-1:0] i_cfg_data
);

    localparam int W  = NUM_WIDTH;
    localparam int CW = $clog2(W + 1);

    localparam t_state S_IDLE = 3'd0;
    localparam t_state S_RED  = 3'd1;
    localparam t_state S_PCHK = 3'd2;
    localparam t_state S_MUL  = 3'd3;
    localparam t_state S_DONE = 3'd4;

    t_state         r_state, n_state;
    logic [W-1:0]   r_mod, r_gen, r_priv;
    logic [W-1:0]   r_acc, n_acc;
    logic [W-1:0]   r_base, n_base;
    logic [W-1:0]   r_rsh, n_rsh;
    logic [W-1:0]   r_e, n_e;
    logic [W-1:0]   r_ma, n_ma;
    logic [W-1:0]   r_mb, n_mb;
    logic [W-1:0]   r_mp, n_mp;
    logic           r_msq, n_msq;
    logic           r_mph, n_mph;
    logic [CW-1:0]  r_cnt, n_cnt;

    // shared modular adder: (x + y + cin) mod m, with x, y < m
    logic [W-1:0]   u_x, u_y, u_out;
    logic           u_cin;
    logic [W:0]     u_sum, u_diff;

    assign u_sum  = {1'b0, u_x} + {1'b0, u_y} + {{W{1'b0}}, u_cin};
    assign u_diff = u_sum - {1'b0, r_mod};
    assign u_out  = (u_sum >= {1'b0, r_mod}) ? u_diff[W-1:0] : u_sum[W-1:0];

    logic accept;
    assign accept      = i_start && (r_state == S_IDLE);
    assign o_busy      = (r_state != S_IDLE);
    assign o_done      = (r_state == S_DONE);
    assign o_result    = r_acc;
    assign o_cfg_ready = (r_state == S_IDLE);

    always_comb begin
        u_x   = r_ma;
        u_y   = r_ma;
        u_cin = 1'b0;
        case (r_state)
            S_RED: begin
                u_x   = r_base;
                u_y   = r_base;
                u_cin = r_rsh[W-1];
            end
            S_MUL: begin
                if (!r_mph && r_mb[0]) begin
                    u_x = r_mp;
                    u_y = r_ma;
                end
            end
            default: begin
                u_cin = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_base  = r_base;
        n_rsh   = r_rsh;
        n_e     = r_e;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_mp    = r_mp;
        n_msq   = r_msq;
        n_mph   = r_mph;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rsh  = (i_op == OP_PUBLIC) ? r_gen : i_value;
                    n_e    = (i_op == OP_PUBLIC) ? i_value : r_priv;
                    n_base = '0;
                    n_cnt  = '0;
                    if (r_mod < W'(2)) begin
                        // every residue is zero
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_acc   = W'(1);
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                // base mod m, one bit a cycle, most significant first
                n_base = u_out;
                n_rsh  = r_rsh << 1;
                n_cnt  = r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    n_state = S_PCHK;
                end
            end
            S_PCHK: begin
                n_mp  = '0;
                n_mph = 1'b0;
                n_ma  = r_base;
                if (r_e == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                    n_mb    = r_e[0] ? r_acc : r_base;
                    n_msq   = !r_e[0];
                end
            end
            S_MUL: begin
                if (r_mb == '0) begin
                    if (!r_msq) begin
                        // acc * base done, follow with base squared
                        n_acc = r_mp;
                        n_mp  = '0;
                        n_ma  = r_base;
                        n_mb  = r_base;
                        n_msq = 1'b1;
                        n_mph = 1'b0;
                    end else begin
                        n_base  = r_mp;
                        n_e     = r_e >> 1;
                        n_state = S_PCHK;
                    end
                end else if (!r_mph && r_mb[0]) begin
                    n_mp  = u_out;
                    n_mph = 1'b1;
                end else begin
                    n_ma  = u_out;
                    n_mb  = r_mb >> 1;
                    n_mph = 1'b0;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mod   <= W'(MOD_RESET);
            r_gen   <= W'(GEN_RESET);
            r_priv  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MODULUS) begin
                    r_mod <= i_cfg_data;
                end else begin
                    r_gen <= i_cfg_data;
                end
            end
            if (accept && (i_op == OP_PUBLIC)) begin
                r_priv <= i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_base <= n_base;
        r_rsh  <= n_rsh;
        r_e    <= n_e;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_mp   <= n_mp;
        r_msq  <= n_msq;
        r_mph  <= n_mph;
        r_cnt  <= n_cnt;
    end

    logic res_ok, mul_ok;
    assign res_ok = (o_result < r_mod) || (r_mod < W'(2));
    assign mul_ok = (r_ma < r_mod) && (r_mp < r_mod);

    `DHM_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, accept, o_busy, "item accepted but not busy")
    `DHM_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !o_busy, "no return to idle after done")
    `DHM_ASSERT_SAME(a_res_range, i_clk, i_rst_n, o_done, res_ok, "result not reduced")
    `DHM_ASSERT_SAME(a_mul_range, i_clk, i_rst_n, r_state == S_MUL, mul_ok, "operand not reduced")

endmodule
